// File: rtl/core/svt_pkg.sv
// ----------------------------------------------------------------------------
// svt_pkg: shared types and constants of the supply voltage tracker
// Register indexes, register reset values, and the structs that pass
// configuration, tracker state and results between the modules.
// ----------------------------------------------------------------------------
package svt_pkg;

  localparam int unsigned CodeW = 8;
  localparam int unsigned VoteW = 8;
  localparam int unsigned VoteHighW = 7;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [1:0] {
    REG_VOTE_HIGH = 2'd0,
    REG_VOTE_LOW  = 2'd1,
    REG_CODE_MIN  = 2'd2,
    REG_CODE_MAX  = 2'd3
  } cfg_idx_e;

  localparam logic [VoteHighW-1:0] VoteHighRst = 7'd8;
  localparam logic signed [VoteW-1:0] VoteLowRst = -8'sd8;
  localparam logic [CodeW-1:0] CodeMinRst = 8'd0;
  localparam logic [CodeW-1:0] CodeMaxRst = 8'd255;

  typedef struct packed {
    logic [VoteHighW-1:0]    vote_high;
    logic signed [VoteW-1:0] vote_low;
    logic [CodeW-1:0]        code_min;
    logic [CodeW-1:0]        code_max;
  } cfg_t;

  typedef struct packed {
    logic signed [VoteW-1:0] vote_count;
    logic [CodeW-1:0]        code_now;
    logic [CodeW-1:0]        hist_newest;
    logic [CodeW-1:0]        hist_older;
  } trk_state_t;

  typedef struct packed {
    logic [CodeW-1:0] threshold_code;
    logic [CodeW-1:0] voltage_estimate;
    logic             stepped_down;
    logic             stepped_up;
  } result_t;

endpackage

// File: rtl/core/supply_voltage_tracker.sv
// ----------------------------------------------------------------------------
// supply_voltage_tracker: tracking comparator voltage monitor
// Input beat to result beat passes two registers (input register, then
// result register). Throughput: one beat per cycle unless a stalled result
// blocks it; the tracker state is updated in the single step between them.
// Reset: code and history start at 0, vote count at 0, registers at defaults.
// ----------------------------------------------------------------------------
module supply_voltage_tracker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  svt_pkg::cfg_idx_e            cfg_idx_i,
  input  logic [svt_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         measure_enable_i,
  input  logic                         sample_first_i,
  input  logic                         sample_second_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [svt_pkg::CodeW-1:0]    threshold_code_o,
  output logic [svt_pkg::CodeW-1:0]    voltage_estimate_o,
  output logic                         stepped_down_o,
  output logic                         stepped_up_o
);
  import svt_pkg::*;

  cfg_t       cfg;
  trk_state_t state_q;
  trk_state_t state_d;
  result_t    res_d;
  result_t    res_q;
  logic       in_vld_q;
  logic       en_q;
  logic       s1_q;
  logic       s2_q;
  logic       out_vld_q;
  logic       advance;
  logic       in_take;

  svt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  svt_step u_step (
    .cfg_i            (cfg),
    .state_i          (state_q),
    .measure_enable_i (en_q),
    .sample_first_i   (s1_q),
    .sample_second_i  (s2_q),
    .state_o          (state_d),
    .result_o         (res_d)
  );

  // result register free or being drained this cycle
  assign advance    = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      en_q <= measure_enable_i;
      s1_q <= sample_first_i;
      s2_q <= sample_second_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.vote_count  <= '0;
      state_q.code_now    <= CodeMinRst;
      state_q.hist_newest <= CodeMinRst;
      state_q.hist_older  <= CodeMinRst;
      out_vld_q           <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
      if (in_vld_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign threshold_code_o   = res_q.threshold_code;
  assign voltage_estimate_o = res_q.voltage_estimate;
  assign stepped_down_o     = res_q.stepped_down;
  assign stepped_up_o       = res_q.stepped_up;

endmodule

// File: rtl/core/svt_cfg_regs.sv
// ----------------------------------------------------------------------------
// svt_cfg_regs: configuration register file
// Holds vote limits and code bounds, written through a plain write port.
// ----------------------------------------------------------------------------
module svt_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  svt_pkg::cfg_idx_e               cfg_idx_i,
  input  logic [svt_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output svt_pkg::cfg_t                   cfg_o
);
  import svt_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vote_high <= VoteHighRst;
      cfg_q.vote_low  <= VoteLowRst;
      cfg_q.code_min  <= CodeMinRst;
      cfg_q.code_max  <= CodeMaxRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_VOTE_HIGH: cfg_q.vote_high <= cfg_wdata_i[VoteHighW-1:0];
        REG_VOTE_LOW:  cfg_q.vote_low  <= $signed(cfg_wdata_i[VoteW-1:0]);
        REG_CODE_MIN:  cfg_q.code_min  <= cfg_wdata_i[CodeW-1:0];
        REG_CODE_MAX:  cfg_q.code_max  <= cfg_wdata_i[CodeW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/svt_step.sv
// ----------------------------------------------------------------------------
// svt_step: one measurement tick of the tracker
// Saturating vote count, down/up code step with clamps, history shift and
// the estimate as the smaller history entry.
// ----------------------------------------------------------------------------
module svt_step (
  input  svt_pkg::cfg_t       cfg_i,
  input  svt_pkg::trk_state_t state_i,
  input  logic                measure_enable_i,
  input  logic                sample_first_i,
  input  logic                sample_second_i,
  output svt_pkg::trk_state_t state_o,
  output svt_pkg::result_t    result_o
);
  import svt_pkg::*;

  logic signed [VoteW:0] hi_ext;
  logic signed [VoteW:0] lo_ext;
  logic signed [VoteW:0] cnt_ext;
  logic signed [VoteW:0] cnt_step;
  logic                  down;
  logic                  up;
  trk_state_t            st_a;
  trk_state_t            st_b;

  always_comb begin
    hi_ext  = $signed({2'b00, cfg_i.vote_high});
    lo_ext  = $signed({cfg_i.vote_low[VoteW-1], cfg_i.vote_low});
    cnt_ext = $signed({state_i.vote_count[VoteW-1], state_i.vote_count});

    // move by one vote, then saturate at the limit in that direction
    cnt_step = cnt_ext;
    if (sample_first_i && sample_second_i) begin
      cnt_step = cnt_ext + 9'sd1;
      if (cnt_step > hi_ext) cnt_step = hi_ext;
    end
    if (!sample_first_i && !sample_second_i) begin
      cnt_step = cnt_ext - 9'sd1;
      if (cnt_step < lo_ext) cnt_step = lo_ext;
    end

    st_a = state_i;
    st_a.vote_count = cnt_step[VoteW-1:0];
    down = measure_enable_i && (cnt_step == hi_ext);
    if (down) begin
      st_a.code_now    = (state_i.code_now <= cfg_i.code_min) ? cfg_i.code_min
                                                              : state_i.code_now - 8'd1;
      st_a.hist_older  = state_i.hist_newest;
      st_a.hist_newest = st_a.code_now;
      st_a.vote_count  = '0;
    end

    // up check sees the counter as the down check left it
    st_b = st_a;
    up = measure_enable_i && ($signed({st_a.vote_count[VoteW-1], st_a.vote_count}) == lo_ext);
    if (up) begin
      st_b.code_now    = (st_a.code_now >= cfg_i.code_max) ? cfg_i.code_max
                                                           : st_a.code_now + 8'd1;
      st_b.hist_older  = st_a.hist_newest;
      st_b.hist_newest = st_b.code_now;
      st_b.vote_count  = '0;
    end

    state_o = measure_enable_i ? st_b : state_i;

    result_o.threshold_code   = state_o.code_now;
    result_o.voltage_estimate = (state_o.hist_older >= state_o.hist_newest) ?
                                state_o.hist_newest : state_o.hist_older;
    result_o.stepped_down     = down;
    result_o.stepped_up       = up;
  end

endmodule

// File: sim/tb_supply_voltage_tracker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_supply_voltage_tracker: self-checking bench for the supply voltage tracker
// Drives measurement beats through the valid/stall input channel and collects
// result beats under random back-pressure. A scoreboard class carries its own
// copy of the vote counter, threshold code and code history, predicts every
// result and compares it field by field. Register settings change between
// phases while the block is empty.
// ----------------------------------------------------------------------------
module tb_supply_voltage_tracker;
  import svt_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  class TrackerScore;
    logic [VoteHighW-1:0]    vote_high;
    logic signed [VoteW-1:0] vote_low;
    logic [CodeW-1:0]        code_min;
    logic [CodeW-1:0]        code_max;
    int                      vote_count;
    logic [CodeW-1:0]        code_now;
    logic [CodeW-1:0]        hist_newest;
    logic [CodeW-1:0]        hist_older;
    result_t                 code_results_q[$];
    int                      mismatches;

    function new();
      vote_high   = VoteHighRst;
      vote_low    = VoteLowRst;
      code_min    = CodeMinRst;
      code_max    = CodeMaxRst;
      vote_count  = 0;
      code_now    = CodeMinRst;
      hist_newest = CodeMinRst;
      hist_older  = CodeMinRst;
      mismatches  = 0;
    endfunction

    function void apply_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_VOTE_HIGH: vote_high = data[VoteHighW-1:0];
        REG_VOTE_LOW:  vote_low = data;
        REG_CODE_MIN:  code_min = data;
        REG_CODE_MAX:  code_max = data;
        default: ;
      endcase
    endfunction

    function void push_code(int code);
      code_now    = code[CodeW-1:0];
      hist_older  = hist_newest;
      hist_newest = code_now;
      vote_count  = 0;
    endfunction

    // Advance the tracker by one input beat and queue the result it gives.
    function void step_tracker(logic en, logic s1, logic s2);
      int      hi;
      int      lo;
      int      n;
      int      c;
      result_t want;
      hi = int'(vote_high);
      lo = int'(vote_low);
      want.stepped_down = 1'b0;
      want.stepped_up   = 1'b0;
      if (en) begin
        if (s1 && s2) begin
          n = vote_count + 1;
          vote_count = (n > hi) ? hi : n;
        end
        if (!s1 && !s2) begin
          n = vote_count - 1;
          vote_count = (n < lo) ? lo : n;
        end
        // down check first, up check on the counter as it stands after it
        if (vote_count == hi) begin
          c = int'(code_now) - 1;
          if (c < int'(code_min)) c = int'(code_min);
          push_code(c);
          want.stepped_down = 1'b1;
        end
        if (vote_count == lo) begin
          c = int'(code_now) + 1;
          if (c > int'(code_max)) c = int'(code_max);
          push_code(c);
          want.stepped_up = 1'b1;
        end
      end
      want.threshold_code   = code_now;
      want.voltage_estimate = (hist_older >= hist_newest) ? hist_newest : hist_older;
      code_results_q.push_back(want);
    endfunction

    task report(string what, int got, int want);
      mismatches++;
      if (mismatches <= 100)
        $display("%0t ns: %s mismatch: got %0d, want %0d", $time, what, got, want);
    endtask

    task check_result(result_t got);
      result_t want;
      if (code_results_q.size() == 0) begin
        report("unexpected result beat, threshold_code", int'(got.threshold_code), 0);
        return;
      end
      want = code_results_q.pop_front();
      if (got.threshold_code !== want.threshold_code)
        report("threshold_code", int'(got.threshold_code), int'(want.threshold_code));
      if (got.voltage_estimate !== want.voltage_estimate)
        report("voltage_estimate", int'(got.voltage_estimate),
               int'(want.voltage_estimate));
      if (got.stepped_down !== want.stepped_down)
        report("stepped_down", int'(got.stepped_down), int'(want.stepped_down));
      if (got.stepped_up !== want.stepped_up)
        report("stepped_up", int'(got.stepped_up), int'(want.stepped_up));
    endtask

    function int pending();
      return code_results_q.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  cfg_idx_e            cfg_idx_i = REG_VOTE_HIGH;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                measure_enable_i = 1'b0;
  logic                sample_first_i = 1'b0;
  logic                sample_second_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [CodeW-1:0]    threshold_code_o;
  logic [CodeW-1:0]    voltage_estimate_o;
  logic                stepped_down_o;
  logic                stepped_up_o;

  TrackerScore tracker;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          stall_left = 0;
  int unsigned cycle_n = 0;

  supply_voltage_tracker DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .measure_enable_i   (measure_enable_i),
    .sample_first_i     (sample_first_i),
    .sample_second_i    (sample_second_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .threshold_code_o   (threshold_code_o),
    .voltage_estimate_o (voltage_estimate_o),
    .stepped_down_o     (stepped_down_o),
    .stepped_up_o       (stepped_up_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_n++;
    if (cycle_n > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver back-pressure in random bursts.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct) begin
      stall_left = $urandom_range(0, 15);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    result_t seen;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen.threshold_code   = threshold_code_o;
        seen.voltage_estimate = voltage_estimate_o;
        seen.stepped_down     = stepped_down_o;
        seen.stepped_up       = stepped_up_o;
        tracker.check_result(seen);
      end
      if (in_valid_i && !in_stall_o)
        tracker.step_tracker(measure_enable_i, sample_first_i, sample_second_i);
    end
  end

  task automatic send_beat(input logic en, input logic s1, input logic s2);
    in_valid_i       <= 1'b1;
    measure_enable_i <= en;
    sample_first_i   <= s1;
    sample_second_i  <= s2;
    do @(posedge clk_i); while (in_stall_o);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  // Hold the sender until every queued result has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    tracker.apply_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [7:0] vh, input logic [7:0] vl,
                          input logic [7:0] cmin, input logic [7:0] cmax);
    put_reg(REG_VOTE_HIGH, vh);
    put_reg(REG_VOTE_LOW, vl);
    put_reg(REG_CODE_MIN, cmin);
    put_reg(REG_CODE_MAX, cmax);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_regs();
    logic [7:0] vh;
    logic [7:0] vl;
    logic [7:0] cmin;
    logic [7:0] cmax;
    case ($urandom_range(0, 7))
      0: vh = 8'd0;
      1: vh = 8'd1;
      2: vh = 8'd127;
      default: vh = 8'($urandom_range(2, 12));
    endcase
    // bit 7 lies beyond the vote_high field and must be dropped
    vh[7] = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0: vl = 8'h80;
      1: vl = 8'hFF;
      2: vl = 8'h00;
      3: vl = 8'($urandom_range(1, 127));
      default: vl = 8'(256 - $urandom_range(2, 12));
    endcase
    case ($urandom_range(0, 3))
      0: cmin = 8'd0;
      1: cmin = 8'd255;
      default: cmin = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 3))
      0: cmax = 8'd0;
      1: cmax = 8'd255;
      default: cmax = 8'($urandom_range(0, 255));
    endcase
    set_regs(vh, vl, cmin, cmax);
  endtask

  // Runs of agreeing samples push the counter to its limits; mixed and idle
  // beats are the noise in between.
  task automatic run_votes(input int count);
    int   done_n;
    int   kind;
    int   run_len;
    logic en;
    logic s1;
    logic s2;
    done_n = 0;
    while (done_n < count) begin
      kind    = $urandom_range(0, 9);
      run_len = $urandom_range(1, 14);
      if (run_len > count - done_n) run_len = count - done_n;
      repeat (run_len) begin
        en = ($urandom_range(0, 15) != 0);
        case (kind)
          0, 1, 2, 3: begin s1 = 1'b1; s2 = 1'b1; end
          4, 5, 6, 7: begin s1 = 1'b0; s2 = 1'b0; end
          default: begin s1 = 1'($urandom_range(0, 1)); s2 = 1'($urandom_range(0, 1)); end
        endcase
        if (kind == 9) en = 1'b0;
        send_beat(en, s1, s2);
        done_n++;
      end
      if ($urandom_range(0, 39) == 0) drain();
    end
  endtask

  initial begin
    logic s1;
    tracker = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle and mixed beats, then a down step from code 0
    send_beat(1'b0, 1'b1, 1'b1);
    send_beat(1'b0, 1'b0, 1'b0);
    send_beat(1'b1, 1'b1, 1'b0);
    send_beat(1'b1, 1'b0, 1'b1);
    repeat (8) send_beat(1'b1, 1'b1, 1'b1);
    repeat (5) send_beat(1'b1, 1'b0, 1'b0);
    drain();
    // counter already below the new low limit
    set_regs(8'd8, 8'hFD, 8'd0, 8'd255);
    send_beat(1'b1, 1'b0, 1'b0);
    repeat (3) send_beat(1'b1, 1'b1, 1'b1);
    drain();
    // counter already above the new high limit
    set_regs(8'd2, 8'hFD, 8'd0, 8'd255);
    send_beat(1'b1, 1'b1, 1'b1);
    drain();
    // zero limits: both steps in one beat
    set_regs(8'd0, 8'h00, 8'd0, 8'd255);
    send_beat(1'b1, 1'b1, 1'b0);
    drain();
    // crossed bounds: code jumps to the bound of the step direction
    set_regs(8'h81, 8'hFF, 8'd200, 8'd100);
    send_beat(1'b1, 1'b1, 1'b1);
    send_beat(1'b1, 1'b0, 1'b0);
    drain();
    set_regs(8'h7F, 8'h7F, 8'd255, 8'd0);
    send_beat(1'b1, 1'b0, 1'b0);
    send_beat(1'b1, 1'b1, 1'b1);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case ($urandom_range(0, 2))
        0: send_idle_pct = 0;
        1: send_idle_pct = 15;
        default: send_idle_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0: recv_stall_pct = 0;
        1: recv_stall_pct = 15;
        default: recv_stall_pct = 40;
      endcase
      random_regs();
      run_votes(20);
      drain();
    end

    // Clear the counter, then climb the code into its top clamp.
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    set_regs(8'h7F, 8'h7F, 8'd0, 8'd255);
    send_beat(1'b1, 1'b0, 1'b0);
    drain();
    set_regs(8'h7F, 8'h00, 8'd0, 8'd255);
    repeat (270) begin
      s1 = 1'($urandom_range(0, 1));
      send_beat(1'b1, s1, s1 ? 1'b0 : 1'($urandom_range(0, 1)));
    end
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_regs();
    run_votes(40);
    drain();

    if (tracker.mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/svt_pkg.sv
rtl/core/svt_cfg_regs.sv
rtl/core/svt_step.sv
rtl/core/supply_voltage_tracker.sv
sim/tb_supply_voltage_tracker.sv
